// ===== design/vibrato_modulated_delay_macros.svh =====
// include guard and assertion helpers for the vibrato delay
`ifndef VIBRATO_MODULATED_DELAY_MACROS_SVH
`define VIBRATO_MODULATED_DELAY_MACROS_SVH

// same-cycle implication
`define VMD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vibrato delay check failed");

// next-cycle implication
`define VMD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vibrato delay check failed");

`endif

// ===== design/vmd_pkg.sv =====
// ----------------------------------------------------------------------------
// vmd_pkg
// Shared constants, codes and the quarter-wave sine table of the vibrato delay.
// ----------------------------------------------------------------------------
package vmd_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int PHASE_BITS     = 24;
   localparam int INC_BITS       = 21;
   localparam int SWEEP_BITS     = 20;
   localparam int LFO_BITS       = 25;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 21;
   localparam int MUL_BITS       = 26;
   localparam int PROD_BITS      = 2 * MUL_BITS;
   localparam int ACC_BITS       = 44;
   localparam int WEIGHT_BITS    = 18;

   localparam int SINE_DEPTH = 256;
   localparam int SINE_BITS  = $clog2(SINE_DEPTH);

   // largest whole-sample back distance (delay plus three), rounded up
   localparam int MAX_BACK_INT = (((1 << SWEEP_BITS) - 1) >> 8) + 4;

   localparam logic [LFO_BITS-1:0] ONE_Q24     = 25'd16777216;
   localparam logic [LFO_BITS-1:0] HALF_Q24    = 25'd8388608;
   localparam logic [LFO_BITS-1:0] QUARTER_Q24 = 25'd4194304;

   localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_PHASE_INC  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SWEEP_SPAN = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WAVEFORM   = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_INTERP     = 2'd3;

   localparam logic [1:0] WAVE_TRIANGLE = 2'd0;
   localparam logic [1:0] WAVE_SQUARE   = 2'd1;
   localparam logic [1:0] WAVE_SAWTOOTH = 2'd2;
   localparam logic [1:0] WAVE_SINE     = 2'd3;

   localparam logic [1:0] INTERP_NEAREST   = 2'd0;
   localparam logic [1:0] INTERP_LINEAR    = 2'd1;
   localparam logic [1:0] INTERP_QUADRATIC = 2'd2;

   typedef logic [LFO_BITS-1:0] sine_table_type [SINE_DEPTH+1];

   // taylor series in q30, rounded to q24
   function automatic sine_table_type build_sine();
      sine_table_type    tbl;
      logic [63:0]       x;
      logic [63:0]       x2;
      logic [63:0]       t;
      logic signed [63:0] sum;
      for (int k = 0; k <= SINE_DEPTH; k++) begin
         x   = (PI_HALF_Q30 * 64'(k)) / SINE_DEPTH;
         x2  = (x * x) >> 30;
         t   = x;
         sum = $signed(x);
         for (int n = 1; n <= 6; n++) begin
            t = ((t * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n & 1) == 1) begin
               sum = sum - $signed(t);
            end else begin
               sum = sum + $signed(t);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         sum = (sum + 64'sd32) >>> 6;
         if (sum > 64'sd16777216) begin
            sum = 64'sd16777216;
         end
         tbl[k] = LFO_BITS'(sum);
      end
      return tbl;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine();

endpackage

// ===== design/vibrato_modulated_delay.sv =====
// ----------------------------------------------------------------------------
// vibrato_modulated_delay
// Stereo delay line whose read tap is swept by a low-frequency oscillator.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one stereo word (left, right) per handshake; req_ready is high
//            only while the block is idle.
//   rsp_*  : one interpolated delayed stereo word per input word, held in an
//            output register until rsp_ready takes it.
//   csr_*  : register writes (phase increment, sweep span, waveform,
//            interpolation); always ready, write only while idle.
// Sequence: an accepted word steps through the lfo, delay, reduction, read
//   position, tap read and product states; the block takes no new word until
//   its result is loaded. One shared 26x26 multiplier handles the sine
//   interpolation, the delay scaling, the quadratic weights and the six
//   tap products in turn, and the store has one read port per channel.
// Reset clears the write pointer and lfo phase and sets the registers to
//   defaults. Stores are not swept; entries unwritten since reset read zero.
// Stall: if the previous result has not been taken, the finished word waits
//   in the last step and the store is written only when it moves out.
// ----------------------------------------------------------------------------
module vibrato_modulated_delay #(
   parameter int DELAY_DEPTH = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [vmd_pkg::SAMPLE_BITS-1:0] req_left_in,
   input  logic signed [vmd_pkg::SAMPLE_BITS-1:0] req_right_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [vmd_pkg::SAMPLE_BITS-1:0] rsp_left_out,
   output logic signed [vmd_pkg::SAMPLE_BITS-1:0] rsp_right_out,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [vmd_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [vmd_pkg::CSR_DATA_BITS-1:0]     csr_data
);

`include "vibrato_modulated_delay_macros.svh"

   localparam int AW        = $clog2(DELAY_DEPTH);
   localparam int PW        = AW + 16;
   localparam int SB        = vmd_pkg::SAMPLE_BITS;
   localparam int WB        = vmd_pkg::WEIGHT_BITS;
   localparam int RED_RAW   = $clog2(vmd_pkg::MAX_BACK_INT / DELAY_DEPTH + 1);
   localparam int RED_STEPS = (RED_RAW < 1) ? 1 : RED_RAW;
   localparam int KW        = (RED_STEPS < 2) ? 1 : $clog2(RED_STEPS);
   localparam logic [63:0] SPAN64 = 64'(DELAY_DEPTH) << 16;

   typedef enum logic [4:0] {
      S_IDLE, S_LFO, S_DLY, S_RED0, S_RED, S_POS,
      S_Q0, S_Q1, S_Q2, S_Q3, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_OUT
   } state_type;

   function automatic logic [AW-1:0] inc_idx(input logic [AW-1:0] v);
      return (v == AW'(DELAY_DEPTH - 1)) ? '0 : AW'(v + 1'b1);
   endfunction

   function automatic logic [AW-1:0] dec_idx(input logic [AW-1:0] v);
      return (v == '0) ? AW'(DELAY_DEPTH - 1) : AW'(v - 1'b1);
   endfunction

   function automatic logic signed [SB-1:0] sat_round(
      input logic signed [vmd_pkg::ACC_BITS-1:0] v);
      logic signed [vmd_pkg::ACC_BITS-1:0] t;
      t = (v + 44'sd32768) >>> 16;
      if (t > $signed(44'((1 << (SB - 1)) - 1))) begin
         return SB'((1 << (SB - 1)) - 1);
      end else if (t < -$signed(44'(1 << (SB - 1)))) begin
         return SB'(1 << (SB - 1));
      end
      return SB'(t);
   endfunction

   state_type state_ff;

   logic [vmd_pkg::INC_BITS-1:0]   phase_inc_ff;
   logic [vmd_pkg::SWEEP_BITS-1:0] sweep_ff;
   logic [1:0]                     wave_ff;
   logic [1:0]                     interp_ff;

   logic [vmd_pkg::PHASE_BITS-1:0] phase_ff;
   logic [AW-1:0]                  wr_idx_ff;
   logic                           mem_full_ff;

   logic signed [SB-1:0] in_l_ff, in_r_ff;
   logic signed [vmd_pkg::PROD_BITS-1:0] prod_ff;
   logic [28:0]          r_ff;
   logic [KW-1:0]        red_k_ff;
   logic [PW-1:0]        pos_ff;
   logic signed [vmd_pkg::WEIGHT_BITS-1:0] w0_ff, w1_ff, w2_ff;
   logic signed [SB-1:0] xl_ff [3];
   logic signed [SB-1:0] xr_ff [3];
   logic signed [vmd_pkg::ACC_BITS-1:0] acc_ff;
   logic signed [SB-1:0] res_l_ff, res_r_ff;
   logic                 rsp_valid_ff;
   logic signed [SB-1:0] rsp_l_ff, rsp_r_ff;

   logic signed [SB-1:0] left_mem  [DELAY_DEPTH];
   logic signed [SB-1:0] right_mem [DELAY_DEPTH];
   logic signed [SB-1:0] rd_l_ff, rd_r_ff;
   logic                 rd_ok_ff;

   // ---------------- lfo ----------------
   logic [1:0]                 quad;
   logic [22:0]                ramp;
   logic [vmd_pkg::SINE_BITS:0] sidx, sidx_n;
   logic [21:0]                sfrac;
   logic [vmd_pkg::LFO_BITS-1:0] sa, sb;
   logic signed [vmd_pkg::MUL_BITS-1:0] sdiff;
   logic signed [vmd_pkg::PROD_BITS-1:0] sstep;
   logic signed [26:0]         ssum;
   logic [vmd_pkg::LFO_BITS-1:0] sclip;
   logic [vmd_pkg::LFO_BITS-1:0] pq, lfo;

   always_comb begin
      quad = phase_ff[23:22];
      ramp = {1'b0, phase_ff[21:0]};
      if (quad[0]) begin
         ramp = 23'h400000 - ramp;
      end
      sidx   = ramp[22:22-vmd_pkg::SINE_BITS];
      sidx_n = (sidx < (vmd_pkg::SINE_BITS+1)'(vmd_pkg::SINE_DEPTH)) ?
               (vmd_pkg::SINE_BITS+1)'(sidx + 1'b1) : sidx;
      sfrac  = {ramp[21-vmd_pkg::SINE_BITS:0], vmd_pkg::SINE_BITS'(0)};
      sa     = vmd_pkg::SINE_TABLE[sidx];
      sb     = vmd_pkg::SINE_TABLE[sidx_n];
      sdiff  = $signed({1'b0, sb}) - $signed({1'b0, sa});
      sstep  = (prod_ff + 52'sd2097152) >>> 22;
      ssum   = $signed({2'b0, sa}) + $signed(sstep[26:0]);
      if (ssum < 0) begin
         sclip = '0;
      end else if (ssum > $signed({2'b0, vmd_pkg::ONE_Q24})) begin
         sclip = vmd_pkg::ONE_Q24;
      end else begin
         sclip = ssum[24:0];
      end
      pq = {1'b0, phase_ff};
      unique case (wave_ff)
         vmd_pkg::WAVE_TRIANGLE: begin
            if (pq < vmd_pkg::QUARTER_Q24) begin
               lfo = vmd_pkg::HALF_Q24 + (pq << 1);
            end else if (pq < 25'd12582912) begin
               lfo = vmd_pkg::ONE_Q24 - ((pq - vmd_pkg::QUARTER_Q24) << 1);
            end else begin
               lfo = (pq - 25'd12582912) << 1;
            end
         end
         vmd_pkg::WAVE_SQUARE: begin
            lfo = (pq < vmd_pkg::HALF_Q24) ? vmd_pkg::ONE_Q24 : '0;
         end
         vmd_pkg::WAVE_SAWTOOTH: begin
            lfo = (pq < vmd_pkg::HALF_Q24) ? vmd_pkg::HALF_Q24 + pq
                                          : pq - vmd_pkg::HALF_Q24;
         end
         default: begin
            lfo = quad[1] ? vmd_pkg::HALF_Q24 - (sclip >> 1)
                          : vmd_pkg::HALF_Q24 + (sclip >> 1);
         end
      endcase
   end

   // ---------------- read position and taps ----------------
   logic [AW-1:0]  tap_i, tap_c;
   logic [15:0]    tap_f;
   logic [PW:0]    pos_r;
   logic [AW:0]    c_raw;
   logic signed [15:0] g;
   logic           is_quad, is_near;
   logic [AW-1:0]  addr0, addr1, addr2, rd_addr;
   logic [63:0]    red_lim, wq64, pos64;

   always_comb begin
      tap_i   = pos_ff[PW-1:16];
      tap_f   = pos_ff[15:0];
      pos_r   = {1'b0, pos_ff} + (PW+1)'(32768);
      c_raw   = pos_r[PW:16];
      tap_c   = (c_raw == (AW+1)'(DELAY_DEPTH)) ? '0 : c_raw[AW-1:0];
      g       = $signed({~pos_r[15], pos_r[14:0]});
      is_quad = (interp_ff == vmd_pkg::INTERP_QUADRATIC);
      is_near = (interp_ff == vmd_pkg::INTERP_NEAREST);
      if (is_quad) begin
         addr0 = dec_idx(tap_c);
         addr1 = tap_c;
         addr2 = inc_idx(tap_c);
      end else if (is_near) begin
         addr0 = tap_c;
         addr1 = tap_c;
         addr2 = tap_c;
      end else begin
         addr0 = tap_i;
         addr1 = inc_idx(tap_i);
         addr2 = tap_i;
      end
      unique case (state_ff)
         S_Q0:    rd_addr = addr0;
         S_Q1:    rd_addr = addr1;
         default: rd_addr = addr2;
      endcase
      red_lim = 64'(DELAY_DEPTH) << (16 + 32'(red_k_ff));
      wq64    = 64'(wr_idx_ff) << 16;
      pos64   = (wq64 >= 64'(r_ff)) ? wq64 - 64'(r_ff) : wq64 + SPAN64 - 64'(r_ff);
   end

   // ---------------- shared multiplier operands ----------------
   logic signed [vmd_pkg::MUL_BITS-1:0] mul_a, mul_b;

   always_comb begin
      unique case (state_ff)
         S_LFO: begin
            mul_a = sdiff;
            mul_b = $signed({4'b0, sfrac});
         end
         S_DLY: begin
            mul_a = $signed({6'b0, sweep_ff});
            mul_b = $signed({1'b0, lfo});
         end
         S_Q0: begin
            mul_a = 26'(g);
            mul_b = 26'(g) - 26'sd65536;
         end
         S_Q1: begin
            mul_a = 26'(g);
            mul_b = 26'(g);
         end
         S_Q2: begin
            mul_a = 26'(g);
            mul_b = 26'(g) + 26'sd65536;
         end
         S_Q3: begin
            mul_a = 26'(w0_ff);
            mul_b = 26'(xl_ff[0]);
         end
         S_M1: begin
            mul_a = 26'(w1_ff);
            mul_b = 26'(xl_ff[1]);
         end
         S_M2: begin
            mul_a = 26'(w2_ff);
            mul_b = 26'(xl_ff[2]);
         end
         S_M3: begin
            mul_a = 26'(w0_ff);
            mul_b = 26'(xr_ff[0]);
         end
         S_M4: begin
            mul_a = 26'(w1_ff);
            mul_b = 26'(xr_ff[1]);
         end
         S_M5: begin
            mul_a = 26'(w2_ff);
            mul_b = 26'(xr_ff[2]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   logic signed [vmd_pkg::PROD_BITS-1:0] rnd17, rnd16;
   logic signed [SB-1:0] rdx_l, rdx_r;
   logic signed [vmd_pkg::ACC_BITS-1:0] acc_sum;
   logic out_free, mem_we;

   assign rnd17    = (prod_ff + 52'sd65536) >>> 17;
   assign rnd16    = (prod_ff + 52'sd32768) >>> 16;
   assign rdx_l    = rd_ok_ff ? rd_l_ff : '0;
   assign rdx_r    = rd_ok_ff ? rd_r_ff : '0;
   assign acc_sum  = acc_ff + prod_ff[vmd_pkg::ACC_BITS-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign mem_we   = (state_ff == S_OUT) && out_free;

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= '0;
         wr_idx_ff    <= '0;
         mem_full_ff  <= 1'b0;
         phase_inc_ff <= 21'd350;
         sweep_ff     <= 20'd122880;
         wave_ff      <= vmd_pkg::WAVE_SQUARE;
         interp_ff    <= vmd_pkg::INTERP_LINEAR;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               vmd_pkg::REG_PHASE_INC:  phase_inc_ff <= csr_data;
               vmd_pkg::REG_SWEEP_SPAN: sweep_ff     <= csr_data[vmd_pkg::SWEEP_BITS-1:0];
               vmd_pkg::REG_WAVEFORM:   wave_ff      <= csr_data[1:0];
               vmd_pkg::REG_INTERP:     interp_ff    <= csr_data[1:0];
            endcase
         end
         if (mem_we) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  in_l_ff  <= req_left_in;
                  in_r_ff  <= req_right_in;
                  state_ff <= S_LFO;
               end
            end
            S_LFO: state_ff <= S_DLY;
            S_DLY: state_ff <= S_RED0;
            S_RED0: begin
               r_ff     <= prod_ff[44:16] + 29'(3 << 16);
               red_k_ff <= KW'(RED_STEPS - 1);
               state_ff <= S_RED;
            end
            S_RED: begin
               // one conditional subtract of depth << k per cycle
               if (64'(r_ff) >= red_lim) begin
                  r_ff <= 29'(64'(r_ff) - red_lim);
               end
               if (red_k_ff == '0) begin
                  state_ff <= S_POS;
               end else begin
                  red_k_ff <= red_k_ff - 1'b1;
               end
            end
            S_POS: begin
               pos_ff   <= PW'(pos64);
               state_ff <= S_Q0;
            end
            S_Q0: state_ff <= S_Q1;
            S_Q1: begin
               w0_ff    <= is_quad ? WB'(rnd17) :
                           (is_near ? '0 : $signed(18'(32'd65536 - 32'(tap_f))));
               xl_ff[0] <= rdx_l;
               xr_ff[0] <= rdx_r;
               state_ff <= S_Q2;
            end
            S_Q2: begin
               w1_ff    <= is_quad ? 18'sd65536 - WB'(rnd16) :
                           (is_near ? 18'sd65536 : $signed({2'b0, tap_f}));
               xl_ff[1] <= rdx_l;
               xr_ff[1] <= rdx_r;
               state_ff <= S_Q3;
            end
            S_Q3: begin
               w2_ff    <= is_quad ? WB'(rnd17) : '0;
               xl_ff[2] <= rdx_l;
               xr_ff[2] <= rdx_r;
               state_ff <= S_M1;
            end
            S_M1: begin
               acc_ff   <= prod_ff[vmd_pkg::ACC_BITS-1:0];
               state_ff <= S_M2;
            end
            S_M2: begin
               acc_ff   <= acc_sum;
               state_ff <= S_M3;
            end
            S_M3: begin
               res_l_ff <= sat_round(acc_sum);
               state_ff <= S_M4;
            end
            S_M4: begin
               acc_ff   <= prod_ff[vmd_pkg::ACC_BITS-1:0];
               state_ff <= S_M5;
            end
            S_M5: begin
               acc_ff   <= acc_sum;
               state_ff <= S_M6;
            end
            S_M6: begin
               res_r_ff <= sat_round(acc_sum);
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_l_ff     <= res_l_ff;
                  rsp_r_ff     <= res_r_ff;
                  wr_idx_ff    <= inc_idx(wr_idx_ff);
                  if (wr_idx_ff == AW'(DELAY_DEPTH - 1)) begin
                     mem_full_ff <= 1'b1;
                  end
                  phase_ff <= phase_ff + vmd_pkg::PHASE_BITS'(phase_inc_ff);
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // ---------------- sample stores ----------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         left_mem[wr_idx_ff]  <= in_l_ff;
         right_mem[wr_idx_ff] <= in_r_ff;
      end
      rd_l_ff  <= left_mem[rd_addr];
      rd_r_ff  <= right_mem[rd_addr];
      // entries past the write pointer are unwritten until the first wrap
      rd_ok_ff <= mem_full_ff || (rd_addr < wr_idx_ff);
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_l_ff;
   assign rsp_right_out = rsp_r_ff;

   `VMD_ASSERT_NXT(a_full_sticky, clock, reset, mem_full_ff, mem_full_ff)
   `VMD_ASSERT_IMP(a_pos_reduced, clock, reset, state_ff == S_POS, 64'(r_ff) < SPAN64)
   `VMD_ASSERT_NXT(a_write_step, clock, reset, mem_we, wr_idx_ff == inc_idx($past(wr_idx_ff)))
   `VMD_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the vibrato modulated delay: a predictor of the
// lfo, the swept read tap and its interpolation checks every output word.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH     = 4096;
   localparam int TAB_DEPTH = 256;
   localparam int WD_LIMIT  = 4000;
   localparam int SBITS     = vmd_pkg::SAMPLE_BITS;

   typedef struct {
      logic signed [SBITS-1:0] left;
      logic signed [SBITS-1:0] right;
   } stereo_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [SBITS-1:0] req_left_in = '0;
   logic signed [SBITS-1:0] req_right_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [SBITS-1:0] rsp_left_out;
   logic signed [SBITS-1:0] rsp_right_out;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [vmd_pkg::CSR_INDEX_BITS-1:0] csr_index = vmd_pkg::REG_PHASE_INC;
   logic [vmd_pkg::CSR_DATA_BITS-1:0] csr_data = '0;

   vibrato_modulated_delay dut (.*);

   // predictor state
   logic signed [SBITS-1:0] left_hist [DEPTH];
   logic signed [SBITS-1:0] right_hist [DEPTH];
   longint sine_quarter [TAB_DEPTH+1];
   int unsigned wr_ptr;
   logic [vmd_pkg::PHASE_BITS-1:0] phase_acc;
   logic [vmd_pkg::INC_BITS-1:0] inc_reg;
   logic [vmd_pkg::SWEEP_BITS-1:0] sweep_reg;
   logic [1:0] wave_reg;
   logic [1:0] interp_reg;

   stereo_word_type delayed_words [$];
   int send_idle_pct;
   int recv_stall_pct;
   int errors;
   int words_in;
   int words_out;
   int quiet_cycles;

   initial forever #4 clock = ~clock;

   function automatic longint rnd_shift(longint v, int sh);
      return (v + (longint'(1) <<< (sh - 1))) >>> sh;
   endfunction

   function automatic longint clip(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   function automatic void make_sine();
      longint unsigned x, x2, t;
      longint sum;
      for (int k = 0; k <= TAB_DEPTH; k++) begin
         x = (64'd1686629713 * longint'(k)) / TAB_DEPTH;
         x2 = (x * x) >> 30;
         t = x;
         sum = longint'(x);
         for (int n = 1; n <= 6; n++) begin
            t = ((t * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) sum -= longint'(t);
            else sum += longint'(t);
         end
         if (sum < 0) sum = 0;
         sum = (sum + 32) >>> 6;
         if (sum > 16777216) sum = 16777216;
         sine_quarter[k] = sum;
      end
   endfunction

   function automatic longint lfo_level(longint p);
      longint q, r, pos, idx, a, b, s;
      case (wave_reg)
         vmd_pkg::WAVE_TRIANGLE: begin
            if (p < 4194304) return 8388608 + 2 * p;
            if (p < 3 * 4194304) return 16777216 - 2 * (p - 4194304);
            return 2 * (p - 3 * 4194304);
         end
         vmd_pkg::WAVE_SQUARE: return (p < 8388608) ? 16777216 : 0;
         vmd_pkg::WAVE_SAWTOOTH: return (p < 8388608) ? 8388608 + p : p - 8388608;
         default: begin
            q = p >> 22;
            r = p & 'h3FFFFF;
            if (q % 2 == 1) r = 'h400000 - r;
            pos = r * TAB_DEPTH;
            idx = pos >> 22;
            if (idx > TAB_DEPTH) idx = TAB_DEPTH;
            a = sine_quarter[idx];
            b = (idx < TAB_DEPTH) ? sine_quarter[idx+1] : a;
            s = a + rnd_shift((b - a) * (pos & 'h3FFFFF), 22);
            if (s < 0) s = 0;
            if (s > 16777216) s = 16777216;
            return (q < 2) ? 8388608 + (s >> 1) : 8388608 - (s >> 1);
         end
      endcase
   endfunction

   function automatic longint hist(bit right, longint i);
      return right ? longint'(right_hist[i]) : longint'(left_hist[i]);
   endfunction

   function automatic longint tap_value(bit right, longint pos);
      longint c, c0, c2, g, w0, w1, w2, acc, a, b, f;
      if (interp_reg == vmd_pkg::INTERP_NEAREST) begin
         return hist(right, ((pos + 'h8000) >> 16) % DEPTH);
      end else if (interp_reg == vmd_pkg::INTERP_QUADRATIC) begin
         c = ((pos + 'h8000) >> 16) % DEPTH;
         c0 = (c + DEPTH - 1) % DEPTH;
         c2 = (c + 1) % DEPTH;
         g = ((pos + 'h8000) & 'hFFFF) - 'h8000;
         w0 = rnd_shift(g * (g - 65536), 17);
         w1 = 65536 - rnd_shift(g * g, 16);
         w2 = rnd_shift(g * (g + 65536), 17);
         acc = w0 * hist(right, c0) + w1 * hist(right, c) + w2 * hist(right, c2);
         return clip(rnd_shift(acc, 16));
      end
      // reserved mode falls through to linear
      a = (pos >> 16) % DEPTH;
      b = (a + 1) % DEPTH;
      f = pos & 'hFFFF;
      acc = f * hist(right, b) + (65536 - f) * hist(right, a);
      return clip(rnd_shift(acc, 16));
   endfunction

   function automatic stereo_word_type advance_delay(logic signed [SBITS-1:0] l,
                                                     logic signed [SBITS-1:0] r);
      longint span, delay, back, pos;
      stereo_word_type w;
      span = longint'(DEPTH) << 16;
      delay = (longint'(sweep_reg) * lfo_level(longint'(phase_acc))) >> 16;
      back = (delay + (longint'(3) << 16)) % span;
      pos = ((longint'(wr_ptr) << 16) + span - back) % span;
      w.left = SBITS'(tap_value(1'b0, pos));
      w.right = SBITS'(tap_value(1'b1, pos));
      left_hist[wr_ptr] = l;
      right_hist[wr_ptr] = r;
      wr_ptr = (wr_ptr + 1) % DEPTH;
      phase_acc = phase_acc + vmd_pkg::PHASE_BITS'(inc_reg);
      return w;
   endfunction

   task automatic send_word(logic signed [SBITS-1:0] l,
                            logic signed [SBITS-1:0] r);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_left_in <= l;
      req_right_in <= r;
      do @(posedge clock); while (!req_ready);
      delayed_words.push_back(advance_delay(l, r));
      words_in++;
      // drop valid so an idle block never takes the word twice
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (delayed_words.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(logic [vmd_pkg::CSR_INDEX_BITS-1:0] idx, int unsigned val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= vmd_pkg::CSR_DATA_BITS'(val);
      do @(posedge clock); while (!csr_ready);
      case (idx)
         vmd_pkg::REG_PHASE_INC: inc_reg = vmd_pkg::INC_BITS'(val);
         vmd_pkg::REG_SWEEP_SPAN: sweep_reg = vmd_pkg::SWEEP_BITS'(val);
         vmd_pkg::REG_WAVEFORM: wave_reg = 2'(val);
         default: interp_reg = 2'(val);
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic setup(int unsigned inc, int unsigned sweep, logic [1:0] wave,
                        logic [1:0] mode);
      drain();
      write_reg(vmd_pkg::REG_PHASE_INC, inc);
      write_reg(vmd_pkg::REG_SWEEP_SPAN, sweep);
      write_reg(vmd_pkg::REG_WAVEFORM, wave);
      write_reg(vmd_pkg::REG_INTERP, mode);
   endtask

   function automatic logic signed [SBITS-1:0] pick_sample();
      case ($urandom_range(5))
         0: return -24'sd8388608;
         1: return 24'sd8388607;
         2: return SBITS'($signed($urandom_range(2000)) - 1000);
         default: return SBITS'($urandom);
      endcase
   endfunction

   // extremes, every waveform and mode, wrap cases
   task automatic test_directed();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_word(24'sd8388607, -24'sd8388608);
      send_word(-24'sd8388608, 24'sd8388607);
      send_word(24'sd0, -24'sd1);
      // zero sweep: tap three words back, all modes incl. reserved
      for (int m = 0; m < 4; m++) begin
         setup(0, 0, vmd_pkg::WAVE_TRIANGLE, 2'(m));
         send_word(24'sd8388607, 24'sd8388607);
         send_word(-24'sd8388608, -24'sd8388608);
         send_word(24'sd1234567, -24'sd7654321);
      end
      // full sweep with square in its high half lands on the write slot
      setup(0, 1047808, vmd_pkg::WAVE_SQUARE, vmd_pkg::INTERP_NEAREST);
      send_word(24'sd77, -24'sd77);
      send_word(24'sd78, -24'sd78);
      // register maxima, past the store, every shape
      for (int wv = 0; wv < 4; wv++) begin
         setup(21'h1FFFFF, 20'hFFFFF, 2'(wv), vmd_pkg::INTERP_QUADRATIC);
         send_word(pick_sample(), pick_sample());
      end
   endtask

   task automatic test_random(int n, int idle, int stall);
      int unsigned inc;
      for (int k = 0; k < n; k++) begin
         if (k % 50 == 0) begin
            case ($urandom_range(3))
               0: inc = $urandom_range(1000);
               1: inc = $urandom_range(1048576);
               2: inc = $urandom_range(21'h1FFFFF);
               default: inc = 0;
            endcase
            setup(inc, ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom,
                  2'($urandom), 2'($urandom));
            send_idle_pct = idle;
            recv_stall_pct = stall;
         end
         send_word(pick_sample(), pick_sample());
      end
   endtask

   // sender holds off until the pipe is empty before every word
   task automatic test_hold_off(int n);
      send_idle_pct = 0;
      recv_stall_pct = 50;
      for (int k = 0; k < n; k++) begin
         while (delayed_words.size() != 0) @(posedge clock);
         send_word(pick_sample(), pick_sample());
      end
   endtask

   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      stereo_word_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         words_out++;
         if (delayed_words.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected word %0d/%0d", rsp_left_out, rsp_right_out);
         end else begin
            w = delayed_words.pop_front();
            if (w.left !== rsp_left_out || w.right !== rsp_right_out) begin
               errors++;
               if (errors <= 10)
                  $display("word %0d: expected %0d/%0d got %0d/%0d", words_out,
                           w.left, w.right, rsp_left_out, rsp_right_out);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WD_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WD_LIMIT);
            $display("** vibrato_modulated_delay: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         left_hist[i] = '0;
         right_hist[i] = '0;
      end
      make_sine();
      wr_ptr = 0;
      phase_acc = '0;
      inc_reg = 350;
      sweep_reg = 122880;
      wave_reg = vmd_pkg::WAVE_SQUARE;
      interp_reg = vmd_pkg::INTERP_LINEAR;
      errors = 0;
      words_in = 0;
      words_out = 0;
      quiet_cycles = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(450, 0, 0);
      test_random(450, 84, 0);
      test_random(450, 0, 84);
      test_random(400, 18, 18);
      test_hold_off(40);
      drain();
      $display("covered %0d words in, %0d checked, all shapes and interpolation modes,",
               words_in, words_out);
      $display("register extremes, tap wrap and random sender/receiver stalls");
      if (errors == 0) begin
         $display("** vibrato_modulated_delay: PASSED **");
      end else begin
         $display("%0d mismatches", errors);
         $display("** vibrato_modulated_delay: FAILED **");
      end
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+design
design/vmd_pkg.sv
design/vibrato_modulated_delay.sv
tb/tb.sv
